@@ rtl/inverted_page_table_linear_probe_defines.svh @@
// assertion macros for the inverted page table checker
`ifndef INVERTED_PAGE_TABLE_LINEAR_PROBE_DEFINES_SVH
`define INVERTED_PAGE_TABLE_LINEAR_PROBE_DEFINES_SVH
// property that holds outside reset
`define IPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// implication checked from the cycle after reset
`define IPT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`endif

@@ rtl/iptlp_pkg.sv @@
// shared types and constants of the inverted page table
package iptlp_pkg;
   localparam int MaxFrames = 256;
   localparam int SlotW = $clog2(MaxFrames);
   localparam int CntW = SlotW + 1;
   localparam int PageW = 17;
   localparam int PidW = 14;
   localparam int KeyW = 48;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_SEARCH = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [PageW-1:0] page;
      logic [PidW-1:0]  pid;
      logic [KeyW-1:0]  key;
   } cmd_type;

   // decimal scale of page: 10^digits
   function automatic logic [23:0] page_scale(input logic [PageW-1:0] p);
      logic [23:0] s;
      begin
         if (p >= 17'd100000) s = 24'd1000000;
         else if (p >= 17'd10000) s = 24'd100000;
         else if (p >= 17'd1000) s = 24'd10000;
         else if (p >= 17'd100) s = 24'd1000;
         else if (p >= 17'd10) s = 24'd100;
         else s = 24'd10;
         return s;
      end
   endfunction
endpackage

@@ rtl/inverted_page_table_linear_probe.sv @@
// top level of the hashed inverted page table with linear probing
// usage:
//   req channel carries one request: tuser = func, tdata = {pid, page}
//   rsp channel returns one result per request: tdata = {frame_index, status}
//   csr_we/csr_wdata write frames_in_use (0 acts as 1, above 256 as 256)
// processing:
//   front stage computes pid*10^digits(page)+page and queues up to two requests
//   back stage reduces the key modulo the frame count, one bit per cycle, then
//   probes the covered slots in turn from the home slot, each in a READ state
//   that reads the slot memory into a register and a TEST state that checks it
// reset:
//   after reset a clearing pass over all 256 slots empties the slot memory;
//   requests are queued meanwhile but not carried out until it ends
// stall:
//   a result waits in the output register while rsp_tready is low; the back end
//   then holds, and the front queue keeps taking requests until it is full
module inverted_page_table_linear_probe (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // page [16:0], pid [30:17]
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status [1:0], frame_index [9:2]
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);
   logic q_valid, q_pop;
   iptlp_pkg::cmd_type q_cmd;
   logic [1:0] status;
   logic [7:0] frame_index;

   iptlp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_func(req_tuser), .in_page(req_tdata[16:0]), .in_pid(req_tdata[30:17]),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
   );

   iptlp_back u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(status), .out_index(frame_index)
   );

   // unused top bit of the request data is ignored
   assign rsp_tdata = {6'd0, frame_index, status};
endmodule

@@ rtl/iptlp_front.sv @@
// front end: takes requests, forms the concatenated key, holds a small queue
module iptlp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_func,
   input  logic [iptlp_pkg::PageW-1:0] in_page,
   input  logic [iptlp_pkg::PidW-1:0]  in_pid,
   output logic                  q_valid,
   input  logic                  q_pop,
   output iptlp_pkg::cmd_type    q_cmd
);
   localparam int PW = iptlp_pkg::PidW + 24;

   iptlp_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   logic [PW-1:0] prod;
   logic [iptlp_pkg::KeyW-1:0] key;

   // pid * scale is 14 x 24 bits, then add page
   assign prod = PW'(in_pid) * PW'(iptlp_pkg::page_scale(in_page));
   assign key = iptlp_pkg::KeyW'(prod) + iptlp_pkg::KeyW'(in_page);
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= '{in_func, in_page, in_pid, key};
   end
endmodule

@@ rtl/iptlp_back.sv @@
// back end: modulo by subtract-shift, then a probe sweep over the slot memory
module iptlp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [8:0]            csr_wdata,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  iptlp_pkg::cmd_type    q_cmd,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status,
   output logic [iptlp_pkg::SlotW-1:0] out_index
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_TEST  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam int SW = iptlp_pkg::SlotW;
   localparam int CW = iptlp_pkg::CntW;
   localparam int KW = iptlp_pkg::KeyW;
   localparam int EW = 1 + iptlp_pkg::PageW + iptlp_pkg::PidW;

   logic [EW-1:0] mem [iptlp_pkg::MaxFrames];
   logic [EW-1:0] rdata_ff;
   logic [2:0]    st_ff;
   logic [8:0]    fiu_ff;
   logic [CW-1:0] n;
   iptlp_pkg::cmd_type cmd_ff;
   logic [KW-1:0] rem_ff;
   logic [KW-1:0] rem_nx;
   logic [5:0]    bit_ff;
   logic [SW-1:0] slot_ff;
   logic [CW-1:0] k_ff;
   logic [8:0]    occ_ff;
   logic [1:0]    stat_ff;
   logic [SW-1:0] idx_ff;
   logic          ov_ff;
   logic [KW-1:0] trial;
   logic [EW-1:0] want;
   logic [SW-1:0] slot_nx;
   logic          unused_occ;

   always_comb begin
      if (fiu_ff == 9'd0) n = CW'(1);
      else if (fiu_ff > 9'(iptlp_pkg::MaxFrames)) n = CW'(iptlp_pkg::MaxFrames);
      else n = CW'(fiu_ff);
      trial = KW'(n) << bit_ff;
      rem_nx = ((trial >> bit_ff) == KW'(n) && rem_ff >= trial) ? rem_ff - trial : rem_ff;
      want = {1'b1, cmd_ff.page, cmd_ff.pid};
      slot_nx = (CW'(slot_ff) + CW'(1) == n) ? '0 : slot_ff + SW'(1);
   end

   assign q_pop = (st_ff == ST_IDLE) && q_valid && !ov_ff;
   assign out_valid = ov_ff;
   assign out_status = stat_ff;
   assign out_index = idx_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[slot_ff];
      if (reset) begin
         st_ff <= ST_CLEAR;
         fiu_ff <= 9'd256;
         slot_ff <= '0;
         ov_ff <= 1'b0;
         occ_ff <= '0;
      end else begin
         if (csr_we) fiu_ff <= csr_wdata;
         if (ov_ff && out_ready && st_ff != ST_OUT) ov_ff <= 1'b0;
         case (st_ff)
            ST_CLEAR: begin
               mem[slot_ff] <= '0;
               slot_ff <= slot_ff + SW'(1);
               if (slot_ff == SW'(iptlp_pkg::MaxFrames - 1)) st_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff <= q_cmd;
                  rem_ff <= q_cmd.key;
                  bit_ff <= 6'(KW - CW);
                  st_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               // one quotient bit per cycle; the home slot is set on the last one
               rem_ff <= rem_nx;
               if (bit_ff == 6'd0) begin
                  slot_ff <= rem_nx[SW-1:0];
                  st_ff <= ST_READ;
                  k_ff <= '0;
               end else bit_ff <= bit_ff - 6'd1;
            end
            ST_READ: begin
               stat_ff <= iptlp_pkg::STAT_NOT_FOUND;
               idx_ff <= '0;
               if (k_ff == '0 && !(cmd_ff.func inside {iptlp_pkg::FUNC_INSERT,
                  iptlp_pkg::FUNC_SEARCH, iptlp_pkg::FUNC_DELETE})) st_ff <= ST_OUT;
               else st_ff <= ST_TEST;
            end
            ST_TEST: begin
               // rdata_ff holds the slot read during the last READ cycle
               if (cmd_ff.func == iptlp_pkg::FUNC_INSERT ? !rdata_ff[EW-1]
                                                         : rdata_ff == want) begin
                  stat_ff <= iptlp_pkg::STAT_OK;
                  idx_ff <= slot_ff;
                  if (cmd_ff.func == iptlp_pkg::FUNC_INSERT) begin
                     mem[slot_ff] <= want;
                     occ_ff <= occ_ff + 9'd1;
                  end else if (cmd_ff.func == iptlp_pkg::FUNC_DELETE) begin
                     mem[slot_ff] <= '0;
                     occ_ff <= occ_ff - 9'd1;
                  end
                  st_ff <= ST_OUT;
               end else if (k_ff + CW'(1) == n) begin
                  stat_ff <= (cmd_ff.func == iptlp_pkg::FUNC_INSERT)
                     ? iptlp_pkg::STAT_FULL : iptlp_pkg::STAT_NOT_FOUND;
                  st_ff <= ST_OUT;
               end else begin
                  k_ff <= k_ff + CW'(1);
                  slot_ff <= slot_nx;
                  st_ff <= ST_READ;
               end
            end
            ST_OUT: begin
               if (!ov_ff || out_ready) begin
                  ov_ff <= 1'b1;
                  st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign unused_occ = ^occ_ff;
endmodule

@@ rtl/iptlp_checker.sv @@
// port-level checker for the inverted page table
`include "inverted_page_table_linear_probe_defines.svh"
module iptlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   `IPT_ASSERT_IMP(a_rsp_hold, rsp_tvalid && !rsp_tready, ##1 $stable(rsp_tdata),
      "rsp changed while stalled")
   `IPT_ASSERT_IMP(a_status_code, rsp_tvalid,
      rsp_tdata[1:0] <= iptlp_pkg::STAT_NOT_FOUND, "bad status code")
   `IPT_ASSERT_IMP(a_idx_zero, rsp_tvalid && rsp_tdata[1:0] != iptlp_pkg::STAT_OK,
      rsp_tdata[9:2] == 8'd0, "index nonzero on error")
   `IPT_ASSERT_IMP(a_no_back2back, rsp_tvalid && rsp_tready, ##1 !rsp_tvalid,
      "result repeated")
endmodule

bind inverted_page_table_linear_probe iptlp_checker u_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

@@ tb/inverted_page_table_linear_probe_checker.sv @@
// checker that predicts and compares results of the inverted page table
module inverted_page_table_linear_probe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] frame_index;
   } lookup_result_type;

   logic [31:0]       slot_word[iptlp_pkg::MaxFrames];
   logic [8:0]        frame_reg;
   lookup_result_type lookup_queue[$];

   function automatic int frames_covered();
      int n;
      n = frame_reg;
      if (n == 0) n = 1;
      if (n > iptlp_pkg::MaxFrames) n = iptlp_pkg::MaxFrames;
      return n;
   endfunction

   function automatic int home_of(logic [16:0] page, logic [13:0] pid, int n);
      longint unsigned scale, p;
      scale = 10;
      p = page;
      while (p >= 10) begin
         p = p / 10;
         scale = scale * 10;
      end
      return int'((longint'(pid) * scale + longint'(page)) % longint'(n));
   endfunction

   // apply one request to the shadow table and return its result
   function automatic lookup_result_type apply_request(logic [1:0] func, logic [16:0] page,
                                                       logic [13:0] pid);
      lookup_result_type r;
      int n, s, k;
      logic [31:0] want;
      n = frames_covered();
      s = home_of(page, pid, n);
      want = {1'b1, page, pid};
      r.status = iptlp_pkg::STAT_NOT_FOUND;
      r.frame_index = '0;
      if (func == iptlp_pkg::FUNC_INSERT) begin
         r.status = iptlp_pkg::STAT_FULL;
         for (k = 0; k < n; k++) begin
            if (!slot_word[s][31]) begin
               slot_word[s] = want;
               r.status = iptlp_pkg::STAT_OK;
               r.frame_index = s[7:0];
               break;
            end
            s = (s + 1 == n) ? 0 : s + 1;
         end
      end else if (func == iptlp_pkg::FUNC_SEARCH || func == iptlp_pkg::FUNC_DELETE) begin
         for (k = 0; k < n; k++) begin
            if (slot_word[s] == want) begin
               r.status = iptlp_pkg::STAT_OK;
               r.frame_index = s[7:0];
               if (func == iptlp_pkg::FUNC_DELETE) slot_word[s] = '0;
               break;
            end
            s = (s + 1 == n) ? 0 : s + 1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type got, want;
      if (reset) begin
         foreach (slot_word[i]) slot_word[i] = '0;
         frame_reg = 9'd256;
         lookup_queue.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_we) frame_reg = csr_wdata;
         if (req_tvalid && req_tready)
            lookup_queue.push_back(apply_request(req_tuser, req_tdata[16:0], req_tdata[30:17]));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.frame_index = rsp_tdata[9:2];
            result_count++;
            if (lookup_queue.size() == 0) begin
               $error("result with no request waiting: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = lookup_queue.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.frame_index !== want.frame_index) begin
                  $error("frame_index expected %0d actual %0d",
                         want.frame_index, got.frame_index);
                  fail_count++;
               end
            end
         end
      end
      pending_count = lookup_queue.size();
   end
endmodule

@@ tb/tb_inverted_page_table_linear_probe.sv @@
// stimulus and verdict for the inverted page table testbench
module tb_inverted_page_table_linear_probe;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [8:0]  csr_wdata = '0;
   int          fail_count, pending_count, result_count;
   int          request_count = 0;

   // pairs already inserted, reused so searches and deletes hit
   logic [16:0] known_page[$];
   logic [13:0] known_pid[$];

   always #1 clock = ~clock;

   inverted_page_table_linear_probe dut (.*);

   inverted_page_table_linear_probe_checker u_checker (.*);

   // result side: a random stall, sometimes none, before each response
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!reset) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         end
      end
   end

   // send one request and wait for acceptance; valid stays up for a next one
   task automatic send_request(input logic [1:0] func, input logic [16:0] page,
                               input logic [13:0] pid, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {1'b0, pid, page};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
      if (func == iptlp_pkg::FUNC_INSERT && known_page.size() < 64) begin
         known_page.push_back(page);
         known_pid.push_back(pid);
      end
   endtask

   // stop sending and wait until every expected result has come
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // drain everything, let the block settle, then write the frame count
   task automatic set_frames(input logic [8:0] value);
      drain();
      repeat (600) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      known_page.delete();
      known_pid.delete();
   endtask

   // searches and deletes mostly reuse known pairs; else small key space or full-range noise
   task automatic random_request(input bit no_gap);
      logic [1:0] func;
      logic [16:0] page;
      logic [13:0] pid;
      int k;
      func = $urandom_range(0, 9) < 5 ? iptlp_pkg::FUNC_INSERT
           : ($urandom_range(0, 1) ? iptlp_pkg::FUNC_SEARCH : iptlp_pkg::FUNC_DELETE);
      if ($urandom_range(0, 19) == 0) func = iptlp_pkg::FUNC_UNUSED;
      if (func != iptlp_pkg::FUNC_INSERT && known_page.size() != 0
          && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, known_page.size() - 1);
         page = known_page[k];
         pid = known_pid[k];
      end else if ($urandom_range(0, 2) == 0) begin
         page = $urandom;
         pid = $urandom;
      end else begin
         page = $urandom_range(0, 99999);
         pid = $urandom_range(0, 9999);
      end
      send_request(func, page, pid, no_gap);
   endtask

   initial begin
      int phase, i;
      logic [8:0] frame_setting[6];
      frame_setting = '{9'd256, 9'd1, 9'd0, 9'd7, 9'd511, 9'd16};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, unused code
      send_request(iptlp_pkg::FUNC_INSERT, 17'd0, 14'd0, 0);
      send_request(iptlp_pkg::FUNC_INSERT, 17'd99999, 14'd9999, 0);
      send_request(iptlp_pkg::FUNC_INSERT, 17'h1FFFF, 14'h3FFF, 0);
      send_request(iptlp_pkg::FUNC_INSERT, 17'd0, 14'd0, 1);
      send_request(iptlp_pkg::FUNC_SEARCH, 17'd0, 14'd0, 0);
      send_request(iptlp_pkg::FUNC_SEARCH, 17'h1FFFF, 14'h3FFF, 0);
      send_request(iptlp_pkg::FUNC_SEARCH, 17'd5, 14'd5, 0);
      send_request(iptlp_pkg::FUNC_UNUSED, 17'd0, 14'd0, 0);
      send_request(iptlp_pkg::FUNC_DELETE, 17'd0, 14'd0, 1);
      send_request(iptlp_pkg::FUNC_SEARCH, 17'd0, 14'd0, 0);
      send_request(iptlp_pkg::FUNC_DELETE, 17'd99999, 14'd9999, 0);
      send_request(iptlp_pkg::FUNC_DELETE, 17'd99999, 14'd9999, 0);
      send_request(iptlp_pkg::FUNC_INSERT, 17'd9, 14'd1, 0);
      send_request(iptlp_pkg::FUNC_INSERT, 17'd10, 14'd1, 0);

      // a tiny table fills quickly so the full status shows up
      set_frames(9'd2);
      for (i = 0; i < 4; i++) send_request(iptlp_pkg::FUNC_INSERT, 17'(i), 14'd3, 1);
      send_request(iptlp_pkg::FUNC_DELETE, 17'd1, 14'd3, 0);
      send_request(iptlp_pkg::FUNC_SEARCH, 17'd0, 14'd3, 0);

      for (phase = 0; phase < 6; phase++) begin
         set_frames(frame_setting[phase]);
         for (i = 0; i < 230; i++) begin
            random_request(i < 20);
            // sender holds off until the block has answered everything
            if (i == 100) drain();
         end
      end

      drain();
      repeat (600) @(posedge clock);
      $display("covered %0d requests and %0d results over frame counts 0 to 511,",
               request_count, result_count);
      $display("including full table, duplicate inserts, misses and the unused code");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog well beyond the worst case per request plus stalls, many times over
   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
